// ----- sv/sdtq_pkg.sv -----
// shared types and constants of the sorted deadline timer queue
// no dependencies
package sdtq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int SEC_W           = 32;
  localparam int USEC_W          = 20;
  localparam int PEND_W          = 5;

  localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);
  localparam logic [USEC_W-1:0] USEC_MAX     = USEC_W'(999999);
  localparam logic [SEC_W-1:0]  SEC_MAX      = {SEC_W{1'b1}};

  typedef enum logic [2:0] {
    ST_REGISTERED = 3'd0,
    ST_FULL       = 3'd1,
    ST_BAD_USEC   = 3'd2,
    ST_EXPIRED    = 3'd3,
    ST_WAITING    = 3'd4,
    ST_EMPTY      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    RD_TAIL = 2'd0,
    RD_NEXT = 2'd1,
    RD_HEAD = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    calc;
    logic    set_idx;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_shift;
    logic    wr_new;
    logic    idx_dec;
    logic    cnt_inc;
    logic    pop;
    logic    res_set;
    status_t res_code;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic kind;
    logic full;
    logic bad_usec;
    logic empty;
    logic idx_zero;
    logic idx_one;
    logic new_earlier;
    logic now_before;
  } dp_sts_t;

endpackage

// ----- sv/sorted_deadline_timer_queue.sv -----
// top level of the sorted deadline timer queue: controller plus datapath
// depends on sdtq_pkg, sdtq_ctrl, sdtq_dp
//
//   channel | handshake           | word
//   in_     | in_valid / in_stall | kind, now_sec, now_usec, delay_sec, delay_usec
//   out_    | out_valid/out_stall | status, deadline_sec/usec, wait_sec/usec, pending
//
// one word at a time; a poll goes through decode, the head read and the result register
// to the output register, an empty poll or a rejected register straight from decode
// a register walks from the tail, shifting the later deadlines (up to depth - 1 of them),
// one per cycle through the single write port of the deadline memory
// synchronous active-low reset empties the queue; memory contents are not cleared
// a held output word lets the next input word in; it waits only at the final handoff
module sorted_deadline_timer_queue import sdtq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [SEC_W-1:0]  in_now_sec,
  input  logic [USEC_W-1:0] in_now_usec,
  input  logic [SEC_W-1:0]  in_delay_sec,
  input  logic [USEC_W-1:0] in_delay_usec,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic [SEC_W-1:0]  out_deadline_sec,
  output logic [USEC_W-1:0] out_deadline_usec,
  output logic [SEC_W-1:0]  out_wait_sec,
  output logic [USEC_W-1:0] out_wait_usec,
  output logic [PEND_W-1:0] out_pending
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sdtq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  sdtq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_kind           (in_kind),
    .in_now_sec        (in_now_sec),
    .in_now_usec       (in_now_usec),
    .in_delay_sec      (in_delay_sec),
    .in_delay_usec     (in_delay_usec),
    .out_status        (out_status),
    .out_deadline_sec  (out_deadline_sec),
    .out_deadline_usec (out_deadline_usec),
    .out_wait_sec      (out_wait_sec),
    .out_wait_usec     (out_wait_usec),
    .out_pending       (out_pending)
  );

endmodule

// ----- sv/sdtq_dp.sv -----
// datapath: deadline memory (circular, sorted), deadline and wait arithmetic,
// result and output word registers; depends on sdtq_pkg
module sdtq_dp import sdtq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  input  logic              in_kind,
  input  logic [SEC_W-1:0]  in_now_sec,
  input  logic [USEC_W-1:0] in_now_usec,
  input  logic [SEC_W-1:0]  in_delay_sec,
  input  logic [USEC_W-1:0] in_delay_usec,
  output logic [2:0]        out_status,
  output logic [SEC_W-1:0]  out_deadline_sec,
  output logic [USEC_W-1:0] out_deadline_usec,
  output logic [SEC_W-1:0]  out_wait_sec,
  output logic [USEC_W-1:0] out_wait_usec,
  output logic [PEND_W-1:0] out_pending
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int DW = SEC_W + USEC_W;

  logic [DW-1:0]     mem [QUEUE_DEPTH];

  logic              kind_r;
  logic [SEC_W-1:0]  now_sec_r;
  logic [USEC_W-1:0] now_usec_r;
  logic [SEC_W-1:0]  delay_sec_r;
  logic [USEC_W-1:0] delay_usec_r;
  logic [DW-1:0]     new_r;
  logic [DW-1:0]     rd_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     idx_r;
  logic [IW-1:0]     head_r;

  status_t           res_status_r;
  logic [DW-1:0]     res_dl_r;
  logic [SEC_W-1:0]  res_wsec_r;
  logic [USEC_W-1:0] res_wusec_r;

  logic [USEC_W-1:0] now_usec_clamp;
  logic [USEC_W:0]   usum;
  logic              ucarry;
  logic [USEC_W-1:0] usec_new;
  logic [SEC_W:0]    ssum;
  logic [DW-1:0]     new_dl;

  logic [CW-1:0]     rd_log;
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     wr_addr;
  logic [IW-1:0]     head_inc;

  logic [SEC_W-1:0]  hd_sec;
  logic [USEC_W-1:0] hd_usec;
  logic              ubor;
  logic [SEC_W-1:0]  wsec;
  logic [USEC_W-1:0] wusec;

  function automatic logic [IW-1:0] phys(input logic [IW-1:0] hd, input logic [CW-1:0] l);
    logic [SW-1:0] s;
    s = SW'(hd) + SW'(l);
    if (s >= SW'(QUEUE_DEPTH)) begin
      s = s - SW'(QUEUE_DEPTH);
    end
    return IW'(s);
  endfunction

  assign now_usec_clamp = (in_now_usec >= USEC_PER_SEC) ? USEC_MAX : in_now_usec;

  // deadline = now + delay with usec carry and seconds saturation
  assign usum     = (USEC_W+1)'(now_usec_r) + (USEC_W+1)'(delay_usec_r);
  assign ucarry   = (usum >= (USEC_W+1)'(USEC_PER_SEC));
  assign usec_new = ucarry ? USEC_W'(usum - (USEC_W+1)'(USEC_PER_SEC)) : USEC_W'(usum);
  assign ssum     = (SEC_W+1)'(now_sec_r) + (SEC_W+1)'(delay_sec_r) + (SEC_W+1)'(ucarry);
  assign new_dl   = ssum[SEC_W] ? {SEC_MAX, USEC_MAX} : {ssum[SEC_W-1:0], usec_new};

  always_comb begin
    case (cmd.rd_sel)
      RD_TAIL: rd_log = idx_r - CW'(1);
      RD_NEXT: rd_log = idx_r - CW'(2);
      RD_HEAD: rd_log = '0;
      default: rd_log = '0;
    endcase
  end

  assign rd_addr  = phys(head_r, rd_log);
  assign wr_addr  = phys(head_r, idx_r);
  assign head_inc = phys(head_r, CW'(1));

  // time left until head deadline
  assign hd_sec  = rd_r[DW-1:USEC_W];
  assign hd_usec = rd_r[USEC_W-1:0];
  assign ubor    = (hd_usec < now_usec_r);
  assign wsec    = hd_sec - now_sec_r - SEC_W'(ubor);
  assign wusec   = ubor ? USEC_W'((USEC_W+1)'(hd_usec) + (USEC_W+1)'(USEC_PER_SEC)
                                  - (USEC_W+1)'(now_usec_r))
                        : (hd_usec - now_usec_r);

  assign sts.kind        = kind_r;
  assign sts.full        = (count_r == CW'(QUEUE_DEPTH));
  assign sts.bad_usec    = (delay_usec_r >= USEC_PER_SEC);
  assign sts.empty       = (count_r == '0);
  assign sts.idx_zero    = (idx_r == '0);
  assign sts.idx_one     = (idx_r == CW'(1));
  assign sts.new_earlier = (new_r < rd_r);
  assign sts.now_before  = ({now_sec_r, now_usec_r} < rd_r);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_r <= mem[rd_addr];
    end
    if (cmd.wr_shift) begin
      mem[wr_addr] <= rd_r;
    end else if (cmd.wr_new) begin
      mem[wr_addr] <= new_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      head_r  <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.pop) begin
        count_r <= count_r - CW'(1);
        head_r  <= head_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r       <= in_kind;
      now_sec_r    <= in_now_sec;
      now_usec_r   <= now_usec_clamp;
      delay_sec_r  <= in_delay_sec;
      delay_usec_r <= in_delay_usec;
    end
    if (cmd.calc) begin
      new_r <= new_dl;
    end
    if (cmd.set_idx) begin
      idx_r <= count_r;
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - CW'(1);
    end
    if (cmd.res_set) begin
      res_status_r <= cmd.res_code;
      case (cmd.res_code)
        ST_REGISTERED: begin
          res_dl_r    <= new_r;
          res_wsec_r  <= '0;
          res_wusec_r <= '0;
        end
        ST_EXPIRED: begin
          res_dl_r    <= rd_r;
          res_wsec_r  <= '0;
          res_wusec_r <= '0;
        end
        ST_WAITING: begin
          res_dl_r    <= rd_r;
          res_wsec_r  <= wsec;
          res_wusec_r <= wusec;
        end
        default: begin
          res_dl_r    <= '0;
          res_wsec_r  <= '0;
          res_wusec_r <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_status        <= res_status_r;
      out_deadline_sec  <= res_dl_r[DW-1:USEC_W];
      out_deadline_usec <= res_dl_r[USEC_W-1:0];
      out_wait_sec      <= res_wsec_r;
      out_wait_usec     <= res_wusec_r;
      out_pending       <= PEND_W'(count_r);
    end
  end

endmodule

// ----- sv/sdtq_ctrl.sv -----
// controller: sequences decode, sorted insert walk, poll and result handoff
// depends on sdtq_pkg
module sdtq_ctrl import sdtq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_RD,
    S_CMP,
    S_PLACE,
    S_POLL,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.kind) begin
          if (sts.full) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = ST_FULL;
            state_nxt    = S_RESULT;
          end else if (sts.bad_usec) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = ST_BAD_USEC;
            state_nxt    = S_RESULT;
          end else begin
            cmd.calc    = 1'b1;
            cmd.set_idx = 1'b1;
            state_nxt   = S_INS_RD;
          end
        end else if (sts.empty) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_EMPTY;
          state_nxt    = S_RESULT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_HEAD;
          state_nxt  = S_POLL;
        end
      end
      S_INS_RD: begin
        if (sts.idx_zero) begin
          state_nxt = S_PLACE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_TAIL;
          state_nxt  = S_CMP;
        end
      end
      S_CMP: begin
        // walk from the tail, shifting later deadlines up by one
        if (sts.new_earlier) begin
          cmd.wr_shift = 1'b1;
          cmd.idx_dec  = 1'b1;
          if (sts.idx_one) begin
            state_nxt = S_PLACE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_NEXT;
          end
        end else begin
          cmd.wr_new   = 1'b1;
          cmd.cnt_inc  = 1'b1;
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_REGISTERED;
          state_nxt    = S_RESULT;
        end
      end
      S_PLACE: begin
        cmd.wr_new   = 1'b1;
        cmd.cnt_inc  = 1'b1;
        cmd.res_set  = 1'b1;
        cmd.res_code = ST_REGISTERED;
        state_nxt    = S_RESULT;
      end
      S_POLL: begin
        cmd.res_set = 1'b1;
        if (sts.now_before) begin
          cmd.res_code = ST_WAITING;
        end else begin
          cmd.pop      = 1'b1;
          cmd.res_code = ST_EXPIRED;
        end
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
